// File: rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// shared types, register indexes and fixed-point helpers for the
// mandelbrot escape-time block
// ----------------------------------------------------------------------------
package mbe_pkg;

	// register indexes on the write port
	localparam logic [1:0] REG_X_ORIGIN   = 2'd0;
	localparam logic [1:0] REG_Y_ORIGIN   = 2'd1;
	localparam logic [1:0] REG_PIXEL_STEP = 2'd2;
	localparam logic [1:0] REG_MAX_ITER   = 2'd3;

	// reset values of the registers
	localparam logic signed [31:0] X_ORIGIN_RST   = -32'sd16777216;
	localparam logic signed [31:0] Y_ORIGIN_RST   = -32'sd16777216;
	localparam logic [30:0]        PIXEL_STEP_RST = 31'd32768;
	localparam logic [15:0]        MAX_ITER_RST   = 16'd256;

	// q8.24 format
	localparam int FRAC_BITS = 24;
	// escape threshold 4.0
	localparam logic [40:0] ESCAPE_LIMIT = 41'd1 << 26;

	localparam logic signed [43:0] S32_MAX = 44'sd2147483647;
	localparam logic signed [43:0] S32_MIN = -44'sd2147483648;

	// point c of one item
	typedef struct packed {
		logic signed [31:0] cr;
		logic signed [31:0] ci;
	} coord_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// saturate a wide signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape-time count of one pixel in q8.24 fixed point
//
// channel  direction  handshake                  payload
// item in  input      start high, busy low       pixel_x, pixel_y
// result   output     done strobe, one cycle     iter_count, escaped
// config   input      wr_en, no wait             wr_index, wr_data
//
// an item is registered in the front (pixel times step) and then waits in a
// two-entry queue until the iteration unit is free; each iteration is a
// multiply state, then a shift, test and update state
// busy rises only when the front holds an item and the queue is full
// results cannot be held off; arst_n clears control and the registers
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbe_pkg::*; #(
	parameter int IMAGE_WIDTH  = 1024,
	parameter int IMAGE_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// item in
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	// configuration writes
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	// result
	output logic        done,
	output logic [15:0] iter_count,
	output logic        escaped
);

	// configuration registers
	logic signed [31:0] x_origin_q;
	logic signed [31:0] y_origin_q;
	logic [30:0]        pixel_step_q;
	logic [15:0]        max_iter_q;

	// front to queue to back
	logic      push;
	coord_t    push_data;
	logic      pop;
	coord_t    head;
	q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q   <= X_ORIGIN_RST;
			y_origin_q   <= Y_ORIGIN_RST;
			pixel_step_q <= PIXEL_STEP_RST;
			max_iter_q   <= MAX_ITER_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_X_ORIGIN:   x_origin_q   <= wr_data;
				REG_Y_ORIGIN:   y_origin_q   <= wr_data;
				REG_PIXEL_STEP: pixel_step_q <= wr_data[30:0];
				REG_MAX_ITER:   max_iter_q   <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// front: clamp the pixel and map it to the complex plane
	mbe_front #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.x_origin   (x_origin_q),
		.y_origin   (y_origin_q),
		.pixel_step (pixel_step_q),
		.q_status   (q_status),
		.push       (push),
		.push_data  (push_data)
	);

	// queue decouples the registered front from the long iteration
	mbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// back: escape-time iteration, one item at a time
	mbe_iter u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_iter   (max_iter_q),
		.q_status   (q_status),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.iter_count (iter_count),
		.escaped    (escaped)
	);

endmodule

// File: rtl/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// accepts pixel items, clamps them to the image and maps them to c
// ----------------------------------------------------------------------------
module mbe_front import mbe_pkg::*; #(
	parameter int IMAGE_WIDTH  = 1024,
	parameter int IMAGE_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [9:0]         pixel_x,
	input  logic [9:0]         pixel_y,
	input  logic signed [31:0] x_origin,
	input  logic signed [31:0] y_origin,
	input  logic [30:0]        pixel_step,
	input  q_status_t          q_status,
	output logic               push,
	output coord_t             push_data
);

	logic        accept;
	logic [9:0]  px;
	logic [9:0]  py;
	logic        valid_s1;
	logic [40:0] prod_x_s1;
	logic [40:0] prod_y_s1;

	// clamp to the last column or row
	always_comb begin
		if (14'(pixel_x) >= 14'(IMAGE_WIDTH)) begin
			px = 10'(IMAGE_WIDTH - 1);
		end else begin
			px = pixel_x;
		end
		if (14'(pixel_y) >= 14'(IMAGE_HEIGHT)) begin
			py = 10'(IMAGE_HEIGHT - 1);
		end else begin
			py = pixel_y;
		end
	end

	assign busy   = valid_s1 & q_status.full;
	assign accept = start & ~busy;
	assign push   = valid_s1 & ~q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_x_s1 <= 41'(px) * 41'(pixel_step);
			prod_y_s1 <= 41'(py) * 41'(pixel_step);
		end
	end

	// origin plus offset, saturated
	always_comb begin
		push_data.cr = sat32(44'(x_origin) + $signed({3'b000, prod_x_s1}));
		push_data.ci = sat32(44'(y_origin) + $signed({3'b000, prod_y_s1}));
	end

endmodule

// File: rtl/mbe_queue.sv
// ----------------------------------------------------------------------------
// mbe_queue
// two-entry queue of c points between front and iteration unit
// ----------------------------------------------------------------------------
module mbe_queue import mbe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  coord_t    push_data,
	input  logic      pop,
	output coord_t    head,
	output q_status_t status
);

	localparam int DEPTH = 2;

	coord_t     mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign status.full  = (count_q == 2'(DEPTH));
	assign status.empty = (count_q == 2'd0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/mbe_iter.sv
// ----------------------------------------------------------------------------
// mbe_iter
// iterates z = z*z + c for one point, a multiply state then an evaluate state per iteration
// ----------------------------------------------------------------------------
module mbe_iter import mbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] max_iter,
	input  q_status_t   q_status,
	input  coord_t      head,
	output logic        pop,
	output logic        done,
	output logic [15:0] iter_count,
	output logic        escaped
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;

	logic [1:0]         state_q;
	logic [15:0]        k_q;
	coord_t             c_q;
	logic signed [31:0] zr_q;
	logic signed [31:0] zi_q;
	logic signed [63:0] prod_rr_q;
	logic signed [63:0] prod_ii_q;
	logic signed [63:0] prod_ri_q;
	logic               done_q;
	logic [15:0]        count_q;
	logic               esc_q;

	logic signed [39:0] sr;
	logic signed [39:0] si;
	logic signed [40:0] dbl_cross;
	logic [40:0]        mag;
	logic               over;
	logic signed [31:0] zr_next;
	logic signed [31:0] zi_next;

	// truncating products, arithmetic shift floors
	always_comb begin
		sr        = 40'(prod_rr_q >>> FRAC_BITS);
		si        = 40'(prod_ii_q >>> FRAC_BITS);
		dbl_cross = 41'(prod_ri_q >>> (FRAC_BITS - 1));
		mag       = 41'(sr) + 41'(si);
		over      = (mag > ESCAPE_LIMIT);
		zr_next   = sat32(44'(sr) - 44'(si) + 44'(c_q.cr));
		zi_next   = sat32(44'(dbl_cross) + 44'(c_q.ci));
	end

	assign pop        = (state_q == ST_IDLE) & ~q_status.empty;
	assign done       = done_q;
	assign iter_count = count_q;
	assign escaped    = esc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (k_q == max_iter) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (over) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					c_q  <= head;
					zr_q <= '0;
					zi_q <= '0;
					k_q  <= '0;
				end
			end
			ST_MUL: begin
				prod_rr_q <= zr_q * zr_q;
				prod_ii_q <= zi_q * zi_q;
				prod_ri_q <= zr_q * zi_q;
				if (k_q == max_iter) begin
					count_q <= k_q;
					esc_q   <= 1'b0;
				end
			end
			ST_EVAL: begin
				if (over) begin
					count_q <= k_q;
					esc_q   <= 1'b1;
				end else begin
					zr_q <= zr_next;
					zi_q <= zi_next;
					k_q  <= k_q + 16'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: tb/sv/tb_mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// self-checking bench for the q8.24 escape-time block
//
// a behavioral predictor works out the iteration count and escape flag of
// every accepted item from its own copy of the view registers; a checker
// compares each done strobe with the oldest expected result. directed
// tests cover the reset view, the iteration limit extremes, saturation of c
// and a zero step; random views with random sender gaps follow
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;
	import mbe_pkg::*;

	localparam int IMG_W = 1024;
	localparam int IMG_H = 1024;
	// binary point of the q8.24 format
	localparam int Q_FRAC = 24;
	// points escape once re^2 + im^2 is above 4.0
	localparam longint ESCAPE_Q824 = longint'(1) << 26;
	localparam longint Q824_MAX = 64'sd2147483647;
	localparam longint Q824_MIN = -64'sd2147483648;
	// roughly how many random items to send
	localparam int RANDOM_ITEMS = 1100;

	// one expected result together with the pixel that caused it
	typedef struct {
		logic [15:0] iter_count;
		logic        escaped;
		logic [9:0]  px;
		logic [9:0]  py;
	} pixel_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;
	logic        done;
	logic [15:0] iter_count;
	logic        escaped;

	// predictor copy of the view registers
	logic signed [31:0] view_x0;
	logic signed [31:0] view_y0;
	logic [30:0]        view_step;
	logic [15:0]        view_limit;

	// results predicted but not yet seen on the result ports
	pixel_result_t pending_results[$];
	pixel_result_t head;
	int            n_errors;
	int            n_random;
	bit            use_gaps;

	mandelbrot_escape_time #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.done      (done),
		.iter_count(iter_count),
		.escaped   (escaped)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// saturate to the signed 32-bit range of a q8.24 value
	function automatic longint clip_q824(input longint v);
		if (v > Q824_MAX) return Q824_MAX;
		if (v < Q824_MIN) return Q824_MIN;
		return v;
	endfunction

	// escape count of one pixel under the current view
	function automatic pixel_result_t predict_escape(input logic [9:0] px_in,
			input logic [9:0] py_in);
		pixel_result_t r;
		longint px, py, cr, ci, zr, zi, re_sq, im_sq, dbl_cross;
		int unsigned k;
		logic esc;
		// pixels past the image edge use the last column or row
		px = longint'(px_in);
		py = longint'(py_in);
		if (px >= IMG_W) px = IMG_W - 1;
		if (py >= IMG_H) py = IMG_H - 1;
		// c = origin + pixel * step, saturated
		cr = clip_q824(longint'(view_x0) + px * longint'(view_step));
		ci = clip_q824(longint'(view_y0) + py * longint'(view_step));
		zr = 0;
		zi = 0;
		k = 0;
		esc = 1'b0;
		// arithmetic right shift of a signed longint drops the low bits,
		// which rounds toward minus infinity
		while (!esc && k < view_limit) begin
			re_sq = (zr * zr) >>> Q_FRAC;
			im_sq = (zi * zi) >>> Q_FRAC;
			if (re_sq + im_sq > ESCAPE_Q824) begin
				esc = 1'b1;
			end else begin
				// doubled cross term: one bit less of shift
				dbl_cross = (zr * zi) >>> (Q_FRAC - 1);
				zi = clip_q824(dbl_cross + ci);
				zr = clip_q824(re_sq - im_sq + cr);
				k++;
			end
		end
		r.iter_count = k[15:0];
		r.escaped = esc;
		r.px = px_in;
		r.py = py_in;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------------

	function automatic void note_error(input string msg);
		n_errors++;
		if (n_errors <= 10) $display("%s", msg);
	endfunction

	// done is a one-cycle strobe; the receiver cannot stall, so every
	// strobe seen at a rising edge is a result
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				note_error($sformatf("unexpected result: iter_count %0d escaped %0b",
					iter_count, escaped));
			end else begin
				head = pending_results.pop_front();
				if (iter_count !== head.iter_count || escaped !== head.escaped) begin
					note_error($sformatf(
						"pixel (%0d,%0d): expected iter_count %0d escaped %0b, got %0d %0b",
						head.px, head.py, head.iter_count, head.escaped,
						iter_count, escaped));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// offer one item from the falling edge and hold it until busy is low at
	// a rising edge; start stays high so back-to-back items need no bubble
	task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
		@(negedge clk);
		start = 1'b1;
		pixel_x = px;
		pixel_y = py;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_escape(px, py));
	endtask

	// start low for a gap set by n, with junk on the pixel fields
	task automatic idle_cycles(input int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			pixel_x = 10'($urandom);
			pixel_y = 10'($urandom);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!use_gaps || roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// every item gives a result, so an empty store means the block is idle
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		case (idx)
			REG_X_ORIGIN: begin
				view_x0 = data;
			end
			REG_Y_ORIGIN: begin
				view_y0 = data;
			end
			REG_PIXEL_STEP: begin
				view_step = data[30:0];
			end
			REG_MAX_ITER: begin
				view_limit = data[15:0];
			end
		endcase
		@(negedge clk);
		wr_en = 1'b0;
		wr_index = 2'($urandom);
		wr_data = $urandom;
	endtask

	// load a whole view once the block has drained; bits above each
	// register width are random and must be ignored
	task automatic set_view(input logic [31:0] x0, input logic [31:0] y0,
			input logic [30:0] step, input logic [15:0] limit);
		wait_idle();
		write_reg(REG_X_ORIGIN, x0);
		write_reg(REG_Y_ORIGIN, y0);
		write_reg(REG_PIXEL_STEP, {1'($urandom), step});
		write_reg(REG_MAX_ITER, {16'($urandom), limit});
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// view straight out of reset: -1-1i corner, 2/1024 step, limit 256
	task automatic test_reset_view();
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		// c = 0, stays inside for the whole limit
		send_pixel(10'd512, 10'd512);
		// c = -0.5, inside
		send_pixel(10'd256, 10'd512);
		send_pixel(10'd1023, 10'd0);
	endtask

	// a limit of zero reports count zero and no escape
	task automatic test_zero_limit();
		set_view(-32'sd33554432, -32'sd16777216, 31'd65536, 16'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd700, 10'd300);
	endtask

	// a limit of one: z0 = 0 never escapes, so every point is inside
	task automatic test_single_iteration();
		set_view(32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 16'd1);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd3, 10'd900);
	endtask

	// largest limit: one point held inside for the full count, one far outside
	task automatic test_long_limit();
		set_view(32'sd0, 32'sd0, 31'd0, 16'hffff);
		send_pixel(10'd1023, 10'd0);
		// c at about 4.16 lies far outside the set and escapes fast
		set_view(32'sh0428f5c3, 32'sd0, 31'd0, 16'hffff);
		send_pixel(10'd17, 10'd999);
	endtask

	// c far outside the q8.24 range clips to the rails
	task automatic test_coord_saturation();
		set_view(32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 16'd16);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd0, 10'd1023);
		set_view(32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 16'd16);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd1, 10'd0);
	endtask

	// zero step: every pixel maps to the origin itself
	task automatic test_zero_step();
		set_view(-32'sd12582912, 32'sd1677721, 31'd0, 16'd64);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd511);
	endtask

	// random views, mostly framing the set so that counts spread out, some
	// with wild registers; limits stay small apart from a few phases
	task automatic test_random_views();
		int kind;
		int n_items;
		logic [31:0] x0, y0;
		logic [30:0] step;
		logic [15:0] limit;
		while (n_random < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			n_items = $urandom_range(60, 120);
			if (kind == 0) begin
				// anything the registers hold, mostly fast escapes and clipping
				x0 = $urandom;
				y0 = $urandom;
				step = 31'($urandom);
				limit = 16'($urandom_range(1, 64));
			end else begin
				// real part in -2.5..-0.5, imaginary in -1.5..-0.5
				x0 = -32'sd41943040 + 32'($urandom_range(0, 33554432));
				y0 = -32'sd25165824 + 32'($urandom_range(0, 16777216));
				// view span from a quarter to about four units
				step = 31'($urandom_range(4096, 65536));
				if (kind == 1) begin
					limit = 16'($urandom_range(301, 1000));
					n_items = 30;
				end else if (kind < 5) begin
					limit = 16'($urandom_range(65, 300));
				end else begin
					limit = 16'($urandom_range(1, 64));
				end
			end
			set_view(x0, y0, step, limit);
			// some phases run without any sender gaps
			use_gaps = ($urandom_range(0, 3) != 0);
			repeat (n_items) begin
				idle_cycles(pick_gap());
				send_pixel(10'($urandom), 10'($urandom));
				n_random++;
			end
			use_gaps = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		n_errors = 0;
		n_random = 0;
		use_gaps = 1'b1;
		view_x0 = X_ORIGIN_RST;
		view_y0 = Y_ORIGIN_RST;
		view_step = PIXEL_STEP_RST;
		view_limit = MAX_ITER_RST;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_reset_view();
		test_zero_limit();
		test_single_iteration();
		test_long_limit();
		test_coord_saturation();
		test_zero_step();
		test_random_views();

		// drain, then leave room for any stray strobe
		wait_idle();
		repeat (50) @(posedge clk);
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#100000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
rtl/mbe_pkg.sv
rtl/mbe_front.sv
rtl/mbe_queue.sv
rtl/mbe_iter.sv
rtl/mandelbrot_escape_time.sv
tb/sv/tb_mandelbrot_escape_time.sv
